// File: sv/mi_pkg.sv
// Shared constants and types for the modular inverse block.
package mi_pkg;

    // Default operand width: value width; the modulus is one bit narrower.
    localparam int DATA_WIDTH_DEF = 64;

    // Sequencer states of the inverse engine.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: sv/mi_if.sv
// Valid/ready channel interfaces for the modular inverse request and result.
interface mi_in_if #(
    parameter int DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [DATA_WIDTH-1:0]   value_a;
    logic [DATA_WIDTH-2:0]   modulus;

    modport source (output valid, output value_a, output modulus, input ready);
    modport sink   (input valid, input value_a, input modulus, output ready);
endinterface

interface mi_out_if #(
    parameter int DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [DATA_WIDTH-2:0]   inverse;
    logic                    exists;

    modport source (output valid, output inverse, output exists, input ready);
    modport sink   (input valid, input inverse, input exists, output ready);
endinterface

// File: sv/mi_divmac.sv
// Shared bit-serial restoring divider that also accumulates quotient times a multiplicand.
module mi_divmac #(
    parameter int DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-2:0] i_divisor,
    input  logic [DATA_WIDTH-1:0] i_mult,
    output logic                  o_done,
    output logic [DATA_WIDTH-2:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_prod
);

    localparam int W     = DATA_WIDTH;
    localparam int M     = DATA_WIDTH - 1;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_dvd;
    logic [M-1:0]     r_rem;
    logic [M-1:0]     r_dvs;
    logic [W-1:0]     r_mult;
    logic [W-1:0]     r_prod;

    logic [W-1:0]     shifted;
    logic [W-1:0]     diff;
    logic             ge;

    // One restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        shifted = {r_rem, r_dvd[W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
    end

    // Control: run for one step per dividend bit, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance remainder and product each step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_mult <= i_mult;
            r_rem  <= '0;
            r_prod <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[W-2:0], 1'b0};
            r_rem  <= ge ? diff[M-1:0] : shifted[M-1:0];
            r_prod <= {r_prod[W-2:0], 1'b0} + (ge ? r_mult : '0);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

// File: sv/modular_inverse.sv
// Top level: modular inverse by the extended Euclidean algorithm on a shared serial divider.
//
//   channel | dir | payload                          | handshake
//   --------+-----+----------------------------------+------------
//   i_in    | in  | value_a (signed), modulus        | valid/ready
//   o_res   | out | inverse, exists                  | valid/ready
//
// One request runs a reduction divide, then one divide per Euclid step on the
// shared divider, and S_DONE then writes the result register. A zero modulus
// goes from S_IDLE straight to S_DONE with no divide. Ready returns in the same
// cycle that the result appears.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// result register. The result register lets a new request enter while the last
// result waits; the sequencer holds a finished result until that register frees.
module modular_inverse #(
    parameter int DATA_WIDTH = mi_pkg::DATA_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mi_in_if.sink    i_in,
    mi_out_if.source o_res
);

    localparam int W = DATA_WIDTH;
    localparam int M = DATA_WIDTH - 1;

    mi_pkg::t_state r_state, n_state;
    logic [M-1:0]   r_m, n_m;
    logic [M-1:0]   r_r, n_r;
    logic [M-1:0]   r_nr, n_nr;
    logic [W-1:0]   r_t, n_t;
    logic [W-1:0]   r_nt, n_nt;
    logic           r_neg, n_neg;
    logic           r_zmod, n_zmod;

    logic           r_out_valid, n_out_valid;
    logic [M-1:0]   r_inv, n_inv;
    logic           r_exists, n_exists;

    logic           div_start;
    logic [W-1:0]   div_dividend;
    logic [M-1:0]   div_divisor;
    logic [W-1:0]   div_mult;
    logic           div_done;
    logic [M-1:0]   div_rem;
    logic [W-1:0]   div_prod;

    logic           in_fire;
    logic           out_free;
    logic [W-1:0]   t_adj;

    mi_divmac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divmac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_mult     (div_mult),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod     (div_prod)
    );

    assign i_in.ready = (r_state == mi_pkg::S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign t_adj      = r_t[W-1] ? (r_t + {1'b0, r_m}) : r_t;

    // Sequence reduction, Euclid steps and result write
    always_comb begin
        n_state      = r_state;
        n_m          = r_m;
        n_r          = r_r;
        n_nr         = r_nr;
        n_t          = r_t;
        n_nt         = r_nt;
        n_neg        = r_neg;
        n_zmod       = r_zmod;
        n_out_valid  = r_out_valid;
        n_inv        = r_inv;
        n_exists     = r_exists;
        div_start    = 1'b0;
        div_dividend = {1'b0, r_r};
        div_divisor  = r_nr;
        div_mult     = r_nt;

        // drop the held result once taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mi_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_m    = i_in.modulus;
                    n_neg  = i_in.value_a[W-1];
                    n_zmod = (i_in.modulus == '0);
                    if (i_in.modulus == '0) begin
                        n_state = mi_pkg::S_DONE;
                    end else begin
                        // reduce the magnitude of the value modulo m
                        div_start    = 1'b1;
                        div_dividend = i_in.value_a[W-1] ? (~i_in.value_a + W'(1))
                                                         : i_in.value_a;
                        div_divisor  = i_in.modulus;
                        div_mult     = '0;
                        n_state      = mi_pkg::S_RED;
                    end
                end
            end
            mi_pkg::S_RED: begin
                if (div_done) begin
                    n_nr    = (r_neg && (div_rem != '0)) ? (r_m - div_rem) : div_rem;
                    n_r     = r_m;
                    n_t     = '0;
                    n_nt    = W'(1);
                    n_state = mi_pkg::S_CHECK;
                end
            end
            mi_pkg::S_CHECK: begin
                if (r_nr == '0) begin
                    n_state = mi_pkg::S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = mi_pkg::S_DIV;
                end
            end
            mi_pkg::S_DIV: begin
                if (div_done) begin
                    // advance the remainder and coefficient pairs
                    n_t     = r_nt;
                    n_nt    = r_t - div_prod;
                    n_r     = r_nr;
                    n_nr    = div_rem;
                    n_state = mi_pkg::S_CHECK;
                end
            end
            mi_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (!r_zmod && (r_r == M'(1))) begin
                        n_inv    = t_adj[M-1:0];
                        n_exists = 1'b1;
                    end else begin
                        n_inv    = '0;
                        n_exists = 1'b0;
                    end
                    n_state = mi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mi_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mi_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_r      <= n_r;
        r_nr     <= n_nr;
        r_t      <= n_t;
        r_nt     <= n_nt;
        r_neg    <= n_neg;
        r_zmod   <= n_zmod;
        r_inv    <= n_inv;
        r_exists <= n_exists;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.inverse = r_inv;
    assign o_res.exists  = r_exists;

endmodule
